// ----- rtl/nbusf_pkg.sv -----
// ----------------------------------------------------------------------------
// nbusf_pkg
// Shared types, constants and helpers for the unbound-body filter.
// ----------------------------------------------------------------------------
package nbusf_pkg;

  localparam int MAX_BODIES = 64;
  localparam int DIMENSIONS = 3;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);
  localparam int Q_W        = 32;
  localparam int MASS_W     = 31;
  localparam int SOFT_W     = 31;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXACT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP   = 2'd3;

  localparam logic [SOFT_W-1:0] SOFT_RST = 31'd41;

  // one stored body
  typedef struct packed {
    logic [2:0][Q_W-1:0] pos;
    logic [2:0][Q_W-1:0] vel;
    logic [Q_W-1:0]      mass;
    logic [Q_W-1:0]      pot;
  } body_t;

  // per-cell controls
  typedef struct packed {
    logic load;
    logic shift;
    logic upd;
  } cell_ctrl_t;

  // energy unit commands
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TARGET,
    CMD_PAIR,
    CMD_FINISH
  } eng_cmd_e;

  function automatic logic [Q_W-1:0] sat_s33(input logic signed [32:0] v);
    logic [Q_W-1:0] r;
    if (v > 33'sd2147483647)       r = 32'h7FFF_FFFF;
    else if (v < -33'sd2147483648) r = 32'h8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic [Q_W-1:0] sat_s49(input logic signed [48:0] v);
    logic [Q_W-1:0] r;
    if (v > 49'sd2147483647)       r = 32'h7FFF_FFFF;
    else if (v < -49'sd2147483648) r = 32'h8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/nbusf_cell.sv -----
// ----------------------------------------------------------------------------
// nbusf_cell
// One body slot of the rotating row; loads, takes its neighbor or updates.
// ----------------------------------------------------------------------------
module nbusf_cell
  import nbusf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  body_t      in_body_i,
  input  body_t      nbr_body_i,
  input  logic       nbr_mark_i,
  input  logic [Q_W-1:0] upd_pot_i,
  input  logic       upd_mark_i,
  output body_t      body_o,
  output logic       mark_o
);

  body_t body_q;
  logic  mark_q;

  // body payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      body_q <= in_body_i;
    end else if (ctrl_i.upd) begin
      body_q.pot <= upd_pot_i;
    end else if (ctrl_i.shift) begin
      body_q <= nbr_body_i;
    end
  end

  // escape mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else if (ctrl_i.upd) begin
      mark_q <= upd_mark_i;
    end else if (ctrl_i.shift) begin
      mark_q <= nbr_mark_i;
    end
  end

  assign body_o = body_q;
  assign mark_o = mark_q;

endmodule

// ----- rtl/nbusf_eng.sv -----
// ----------------------------------------------------------------------------
// nbusf_eng
// Energy unit: pair distance, 1/sqrt by bit-serial divide and root, mass
// accumulate, then kinetic term and final energy of the head body.
// ----------------------------------------------------------------------------
module nbusf_eng
  import nbusf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eng_cmd_e          cmd_i,
  input  body_t             head_i,
  input  logic              exact_i,
  input  logic [SOFT_W-1:0] soft_i,
  output logic              done_o,
  output logic [Q_W-1:0]    energy_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_MAC  = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam logic [1:0] K_LAST = 2'(DIMENSIONS - 1);

  logic [2:0]          state_q;
  logic                mode_q;     // 1 pair, 0 finish
  logic [1:0]          k_q;
  logic [2:0][Q_W-1:0] tgt_q;
  logic [63:0]         mul_q;
  logic [63:0]         sum_q;
  logic [49:0]         dv_q;
  logic [49:0]         rem_q;
  logic [48:0]         quo_q;
  logic [5:0]          cnt_q;
  logic [48:0]         x_q;
  logic [49:0]         r_q;
  logic [48:0]         bit_q;
  logic signed [57:0]  prod_q;
  logic signed [63:0]  acc_q;
  logic [Q_W-1:0]      energy_q;
  logic                done_q;

  logic [32:0] diff, opnd;
  logic [31:0] mag;
  logic [63:0] sum_nxt;
  logic [50:0] shifted;
  logic        qbit;
  logic [49:0] rem_nxt;
  logic [49:0] trial;
  logic [Q_W-1:0] kin, phi;

  // magnitude for the current dimension
  always_comb begin
    diff = 33'($signed({tgt_q[k_q][31], tgt_q[k_q]})
              - $signed({head_i.pos[k_q][31], head_i.pos[k_q]}));
    opnd = mode_q ? diff : {head_i.vel[k_q][31], head_i.vel[k_q]};
    mag  = opnd[32] ? 32'(-opnd) : opnd[31:0];
  end

  assign sum_nxt = mode_q ? (sum_q + {16'b0, mul_q[63:16]}) : (sum_q + mul_q);

  // restoring divide step
  always_comb begin
    shifted = {rem_q, (cnt_q == 6'd48)};
    qbit    = (shifted >= {1'b0, dv_q});
    rem_nxt = qbit ? 50'(shifted - {1'b0, dv_q}) : shifted[49:0];
  end

  assign trial = r_q + {1'b0, bit_q};

  // finish terms
  always_comb begin
    kin = (sum_q[63:48] != 16'b0) ? 32'h7FFF_FFFF : {1'b0, sum_q[47:17]};
    phi = exact_i ? sat_s49(-$signed({acc_q[63], acc_q[63:16]})) : head_i.pot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_i == CMD_PAIR || cmd_i == CMD_FINISH) state_q <= S_MUL;
        end
        S_MUL:  state_q <= S_ADD;
        S_ADD: begin
          if (k_q != K_LAST)  state_q <= S_MUL;
          else if (mode_q)    state_q <= S_DIV;
          else                state_q <= S_FIN;
        end
        S_DIV:  if (cnt_q == 6'd0) state_q <= S_SQRT;
        S_SQRT: if (bit_q == 49'd1) state_q <= S_MAC;
        S_MAC:  state_q <= S_ACC;
        S_ACC: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        S_FIN: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        k_q   <= 2'd0;
        sum_q <= {33'b0, soft_i};
        if (cmd_i == CMD_TARGET) begin
          tgt_q <= head_i.pos;
          acc_q <= '0;
        end
        if (cmd_i == CMD_PAIR) mode_q <= 1'b1;
        if (cmd_i == CMD_FINISH) begin
          mode_q <= 1'b0;
          sum_q  <= '0;
        end
      end
      S_MUL: mul_q <= mag * mag;
      S_ADD: begin
        sum_q <= sum_nxt;
        k_q   <= k_q + 2'd1;
        dv_q  <= (sum_nxt == 64'b0) ? 50'd1 : sum_nxt[49:0];
        rem_q <= '0;
        cnt_q <= 6'd48;
      end
      S_DIV: begin
        rem_q <= rem_nxt;
        quo_q <= {quo_q[47:0], qbit};
        cnt_q <= cnt_q - 6'd1;
        x_q   <= {quo_q[47:0], qbit};
        r_q   <= '0;
        bit_q <= 49'd1 << 48;
      end
      S_SQRT: begin
        if ({1'b0, x_q} >= trial) begin
          x_q <= x_q - trial[48:0];
          r_q <= (r_q >> 1) + {1'b0, bit_q};
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_MAC: prod_q <= $signed(head_i.mass) * $signed({1'b0, r_q[24:0]});
      S_ACC: acc_q <= acc_q + {{6{prod_q[57]}}, prod_q};
      S_FIN: energy_q <= sat_s33($signed({phi[31], phi}) + $signed({kin[31], kin}));
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign energy_o = energy_q;

endmodule

// ----- rtl/nbody_unbound_star_filter_top.sv -----
// ----------------------------------------------------------------------------
// nbody_unbound_star_filter_top
// Loads a snapshot into a rotating row of body cells, finds each body's
// energy, marks escapers and streams out the selected bodies in load order.
// ----------------------------------------------------------------------------
// Loading: one body per cycle, input accepted whenever no snapshot is in work.
// Closing, supplied potentials: a finish pass in the energy unit per body,
// then one output step per body (selected or not), plus any output stall.
// Closing, exact mode: n*(n-1) body pairs, each a 49-step divider and 25-step
// root in the energy unit, plus the finish pass and one output step per body.
// Reset clears control state and registers; the body store needs no clearing.
// ----------------------------------------------------------------------------
module nbody_unbound_star_filter_top
  import nbusf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [Q_W-1:0]       cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [Q_W-1:0]       pos_x_i,
  input  logic [Q_W-1:0]       pos_y_i,
  input  logic [Q_W-1:0]       pos_z_i,
  input  logic [Q_W-1:0]       vel_x_i,
  input  logic [Q_W-1:0]       vel_y_i,
  input  logic [Q_W-1:0]       vel_z_i,
  input  logic [Q_W-1:0]       body_mass_in_i,
  input  logic [Q_W-1:0]       potential_in_i,
  input  logic                 last_body_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     body_index_o,
  output logic [Q_W-1:0]       out_pos_x_o,
  output logic [Q_W-1:0]       out_pos_y_o,
  output logic [Q_W-1:0]       out_pos_z_o,
  output logic [Q_W-1:0]       out_vel_x_o,
  output logic [Q_W-1:0]       out_vel_y_o,
  output logic [Q_W-1:0]       out_vel_z_o,
  output logic [MASS_W-1:0]    out_mass_o,
  output logic [Q_W-1:0]       total_energy_o,
  output logic                 none_selected_o,
  output logic                 last_result_o
);

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_PHASE = 4'd1;
  localparam logic [3:0] ST_PAIR  = 4'd2;
  localparam logic [3:0] ST_WPAIR = 4'd3;
  localparam logic [3:0] ST_FIN   = 4'd4;
  localparam logic [3:0] ST_WFIN  = 4'd5;
  localparam logic [3:0] ST_NEXT  = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;
  localparam logic [3:0] ST_NONE  = 4'd8;

  // configuration registers
  logic [SOFT_W-1:0] soft_q;
  logic [Q_W-1:0]    cutoff_q;
  logic              exact_q, keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_q   <= SOFT_RST;
      cutoff_q <= '0;
      exact_q  <= 1'b0;
      keep_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SOFT:   soft_q   <= cfg_data_i[SOFT_W-1:0];
        CFG_CUTOFF: cutoff_q <= cfg_data_i;
        CFG_EXACT:  exact_q  <= cfg_data_i[0];
        CFG_KEEP:   keep_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control state
  logic [3:0]       state_q;
  logic [CNT_W-1:0] count_q, n_q, pc_q, sel_q, rem_q;
  logic [IDX_W-1:0] i_q;
  logic             out_valid_q;

  body_t      in_body;
  body_t      cell_body [MAX_BODIES];
  logic [MAX_BODIES-1:0] cell_mark;
  cell_ctrl_t ctrl [MAX_BODIES];

  logic           accept, rot, upd, slot_free, head_want, new_mark, emit, i_last;
  eng_cmd_e       cmd;
  logic           eng_done;
  logic [Q_W-1:0] energy;

  assign in_body.pos  = {pos_z_i, pos_y_i, pos_x_i};
  assign in_body.vel  = {vel_z_i, vel_y_i, vel_x_i};
  assign in_body.mass = body_mass_in_i;
  assign in_body.pot  = potential_in_i;

  assign in_stall_o = (state_q != ST_LOAD);
  assign accept     = in_valid_i & ~in_stall_o;
  assign slot_free  = ~out_valid_q | ~out_stall_i;
  assign head_want  = keep_q ? ~cell_mark[0] : cell_mark[0];
  assign new_mark   = ($signed(energy) >= $signed(cutoff_q));
  assign i_last     = ({1'b0, i_q} == CNT_W'(n_q - 1'b1));

  // sequencer outputs
  always_comb begin
    rot  = 1'b0;
    upd  = 1'b0;
    emit = 1'b0;
    cmd  = CMD_NONE;
    unique case (state_q)
      ST_PHASE: begin
        cmd = CMD_TARGET;
        rot = exact_q;
      end
      ST_PAIR:  if (pc_q != '0) cmd = CMD_PAIR;
      ST_WPAIR: rot = eng_done;
      ST_FIN:   cmd = CMD_FINISH;
      ST_WFIN:  upd = eng_done;
      ST_NEXT:  rot = 1'b1;
      ST_EMIT: begin
        if (!head_want || slot_free) begin
          rot  = 1'b1;
          emit = head_want;
        end
      end
      default: ;
    endcase
  end

  // row of body cells
  for (genvar k = 0; k < MAX_BODIES; k++) begin : g_cell
    body_t nbr_body;
    logic  nbr_mark;
    if (k == MAX_BODIES - 1) begin : g_end
      assign nbr_body = cell_body[0];
      assign nbr_mark = cell_mark[0];
    end else begin : g_mid
      assign nbr_body = (n_q == CNT_W'(k + 1)) ? cell_body[0] : cell_body[k+1];
      assign nbr_mark = (n_q == CNT_W'(k + 1)) ? cell_mark[0] : cell_mark[k+1];
    end
    assign ctrl[k].load  = accept && (count_q == CNT_W'(k));
    assign ctrl[k].shift = rot;
    assign ctrl[k].upd   = upd && (k == 0);

    nbusf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[k]),
      .in_body_i  (in_body),
      .nbr_body_i (nbr_body),
      .nbr_mark_i (nbr_mark),
      .upd_pot_i  (energy),
      .upd_mark_i (new_mark),
      .body_o     (cell_body[k]),
      .mark_o     (cell_mark[k])
    );
  end

  nbusf_eng u_eng (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .head_i   (cell_body[0]),
    .exact_i  (exact_q),
    .soft_i   (soft_q),
    .done_o   (eng_done),
    .energy_o (energy)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      n_q     <= '0;
      pc_q    <= '0;
      sel_q   <= '0;
      rem_q   <= '0;
      i_q     <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (count_q != CNT_W'(MAX_BODIES)) count_q <= count_q + 1'b1;
            if (last_body_i) begin
              n_q     <= (count_q != CNT_W'(MAX_BODIES)) ? count_q + 1'b1 : count_q;
              i_q     <= '0;
              sel_q   <= '0;
              state_q <= ST_PHASE;
            end
          end
        end
        ST_PHASE: begin
          pc_q    <= n_q - 1'b1;
          state_q <= exact_q ? ST_PAIR : ST_FIN;
        end
        ST_PAIR:  state_q <= (pc_q == '0) ? ST_FIN : ST_WPAIR;
        ST_WPAIR: begin
          if (eng_done) begin
            pc_q    <= pc_q - 1'b1;
            state_q <= ST_PAIR;
          end
        end
        ST_FIN:   state_q <= ST_WFIN;
        ST_WFIN: begin
          if (eng_done) begin
            if (keep_q ? ~new_mark : new_mark) sel_q <= sel_q + 1'b1;
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (i_last) begin
            i_q     <= '0;
            rem_q   <= sel_q;
            state_q <= (sel_q == '0) ? ST_NONE : ST_EMIT;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= ST_PHASE;
          end
        end
        ST_EMIT: begin
          if (rot) begin
            if (emit) rem_q <= rem_q - 1'b1;
            if (i_last) begin
              count_q <= '0;
              state_q <= ST_LOAD;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
        end
        ST_NONE: begin
          if (slot_free) begin
            count_q <= '0;
            state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit || (state_q == ST_NONE && slot_free)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  logic [IDX_W-1:0]  idx_q;
  body_t             ob_q;
  logic [MASS_W-1:0] mass_q;
  logic              none_q, last_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      idx_q  <= i_q;
      ob_q   <= cell_body[0];
      mass_q <= (cell_body[0].mass == 32'h8000_0000) ? 31'h7FFF_FFFF
              : (cell_body[0].mass[31] ? 31'(-cell_body[0].mass)
                                       : cell_body[0].mass[30:0]);
      none_q <= 1'b0;
      last_q <= (rem_q == CNT_W'(1));
    end else if (state_q == ST_NONE && slot_free) begin
      idx_q  <= '0;
      ob_q   <= '0;
      mass_q <= '0;
      none_q <= 1'b1;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign body_index_o    = idx_q;
  assign out_pos_x_o     = ob_q.pos[0];
  assign out_pos_y_o     = ob_q.pos[1];
  assign out_pos_z_o     = ob_q.pos[2];
  assign out_vel_x_o     = ob_q.vel[0];
  assign out_vel_y_o     = ob_q.vel[1];
  assign out_vel_z_o     = ob_q.vel[2];
  assign out_mass_o      = mass_q;
  assign total_energy_o  = ob_q.pot;
  assign none_selected_o = none_q;
  assign last_result_o   = last_q;

endmodule

// ----- verif/tb_nbody_unbound_star_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nbody_unbound_star_filter_top
// Sends body snapshots with random gaps while the result side stalls at
// random. The energy of every body is predicted here: supplied or direct-sum
// potential plus half the squared speed. The selected bodies are checked
// field by field, in order, against the prediction.
// ----------------------------------------------------------------------------
module tb_nbody_unbound_star_filter_top;
  import nbusf_pkg::*;

  localparam longint QMAX       = 64'sd2147483647;
  localparam longint QMIN       = -64'sd2147483648;
  localparam int     IDLE_LIMIT = 200000;

  typedef struct {
    logic [Q_W-1:0] pos [3];
    logic [Q_W-1:0] vel [3];
    logic [Q_W-1:0] mass;
    logic [Q_W-1:0] pot;
    logic           last;
  } body_in_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [Q_W-1:0]    pos [3];
    logic [Q_W-1:0]    vel [3];
    logic [MASS_W-1:0] mass;
    logic [Q_W-1:0]    energy;
    logic              none;
    logic              last;
  } selected_body_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_SOFT;
  logic [Q_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [Q_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [Q_W-1:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [Q_W-1:0] body_mass_in_i = '0, potential_in_i = '0;
  logic last_body_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [IDX_W-1:0] body_index_o;
  logic [Q_W-1:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic [Q_W-1:0] out_vel_x_o, out_vel_y_o, out_vel_z_o;
  logic [MASS_W-1:0] out_mass_o;
  logic [Q_W-1:0] total_energy_o;
  logic none_selected_o, last_result_o;

  nbody_unbound_star_filter_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state: registers and the snapshot being loaded
  longint          soft_sq = 41;
  longint          cutoff  = 0;
  bit              exact   = 1'b0;
  bit              keep    = 1'b1;
  longint          snap_pos [3][MAX_BODIES];
  longint          snap_vel [3][MAX_BODIES];
  longint          snap_mass [MAX_BODIES];
  longint          snap_pot [MAX_BODIES];
  int              loaded = 0;
  selected_body_t  pending_q [$];

  int  errors = 0;
  int  idle_cycles = 0;
  int  bodies_sent = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint sat_q(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // truncated 1/sqrt(eps^2 + r^2) between two stored bodies, Q16.16
  function automatic longint inv_distance(input int i, input int j);
    longint unsigned s, d;
    longint diff;
    s = soft_sq;
    for (int k = 0; k < DIMENSIONS; k++) begin
      diff = snap_pos[k][i] - snap_pos[k][j];
      d = (diff < 0) ? -diff : diff;
      s += (d * d) >> 16;
    end
    if (s == 0) s = 1;
    return longint'(int_sqrt((64'd1 << 48) / s));
  endfunction

  // close the snapshot: energies, escape marks, queue the selected bodies
  task automatic predict_selection();
    longint phi, acc, e, m;
    longint unsigned v2, a;
    bit esc;
    selected_body_t r;
    int cnt;
    cnt = 0;
    for (int i = 0; i < loaded; i++) begin
      phi = snap_pot[i];
      if (exact) begin
        acc = 0;
        for (int j = 0; j < loaded; j++)
          if (j != i) acc += snap_mass[j] * inv_distance(i, j);
        phi = sat_q(-(acc >>> 16));
      end
      v2 = 0;
      for (int k = 0; k < DIMENSIONS; k++) begin
        a = (snap_vel[k][i] < 0) ? -snap_vel[k][i] : snap_vel[k][i];
        v2 += a * a;
      end
      e = sat_q(phi + sat_q(longint'(v2 >> 17)));
      esc = (e >= cutoff);
      if (keep != esc) begin
        m = (snap_mass[i] < 0) ? -snap_mass[i] : snap_mass[i];
        r.idx = i[IDX_W-1:0];
        for (int k = 0; k < 3; k++) begin
          r.pos[k] = snap_pos[k][i][31:0];
          r.vel[k] = snap_vel[k][i][31:0];
        end
        r.mass = (m > QMAX) ? QMAX[30:0] : m[30:0];
        r.energy = e[31:0];
        r.none = 1'b0;
        r.last = 1'b0;
        pending_q.push_back(r);
        cnt++;
      end
    end
    if (cnt == 0) begin
      r.idx = '0;
      for (int k = 0; k < 3; k++) begin
        r.pos[k] = '0;
        r.vel[k] = '0;
      end
      r.mass = '0;
      r.energy = '0;
      r.none = 1'b1;
      r.last = 1'b1;
      pending_q.push_back(r);
    end else begin
      pending_q[pending_q.size() - 1].last = 1'b1;
    end
    loaded = 0;
  endtask

  // one body transfer; called right after a rising edge
  task automatic send_body(input body_in_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pos_x_i        <= b.pos[0];
    pos_y_i        <= b.pos[1];
    pos_z_i        <= b.pos[2];
    vel_x_i        <= b.vel[0];
    vel_y_i        <= b.vel[1];
    vel_z_i        <= b.vel[2];
    body_mass_in_i <= b.mass;
    potential_in_i <= b.pot;
    last_body_i    <= b.last;
    do @(posedge clk_i); while (in_stall_o);
    bodies_sent++;
    if (loaded < MAX_BODIES) begin
      for (int k = 0; k < 3; k++) begin
        snap_pos[k][loaded] = longint'(signed'(b.pos[k]));
        snap_vel[k][loaded] = longint'(signed'(b.vel[k]));
      end
      snap_mass[loaded] = longint'(signed'(b.mass));
      snap_pot[loaded]  = longint'(signed'(b.pot));
      loaded++;
    end
    if (b.last) predict_selection();
  endtask

  // wait until every expected result has come and the block takes input again
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0 || in_stall_o) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // one register write; the enable is dropped by the caller
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SOFT:   soft_sq = longint'(data[30:0]);
      CFG_CUTOFF: cutoff  = longint'(signed'(data));
      CFG_EXACT:  exact   = data[0];
      CFG_KEEP:   keep    = data[0];
      default: ;
    endcase
  endtask

  task automatic set_all(input longint soft_val, input longint cut, input bit ex,
                         input bit kp);
    set_reg(CFG_SOFT, soft_val[31:0]);
    set_reg(CFG_CUTOFF, cut[31:0]);
    set_reg(CFG_EXACT, {31'd0, ex});
    set_reg(CFG_KEEP, {31'd0, kp});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [Q_W-1:0] rand_q(input bit wide);
    if (wide) return $urandom;
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic body_in_t rand_body(input bit wide, input bit last);
    body_in_t b;
    for (int k = 0; k < 3; k++) begin
      b.pos[k] = rand_q(wide);
      b.vel[k] = rand_q(wide);
    end
    b.mass = rand_q(wide);
    b.pot  = rand_q(wide);
    b.last = last;
    return b;
  endfunction

  function automatic body_in_t fill_body(input logic [Q_W-1:0] v, input bit last);
    body_in_t b;
    for (int k = 0; k < 3; k++) begin
      b.pos[k] = v;
      b.vel[k] = v;
    end
    b.mass = v;
    b.pot  = v;
    b.last = last;
    return b;
  endfunction

  // extreme field values with supplied potentials, both selections
  task automatic test_extremes();
    logic [Q_W-1:0] vals [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                 32'h0001_0000, 32'hFFFF_0000};
    for (int pass = 0; pass < 2; pass++) begin
      set_all(41, 0, 1'b0, pass == 0);
      for (int i = 0; i < 6; i++) send_body(fill_body(vals[i], i == 5));
      wait_idle();
    end
  endtask

  // more bodies than the store holds; the extra ones are dropped
  task automatic test_store_full();
    set_all(41, 32'h0000_8000, 1'b0, 1'b1);
    for (int i = 0; i < MAX_BODIES + 3; i++)
      send_body(rand_body(1'b0, i == MAX_BODIES + 2));
    wait_idle();
  endtask

  // cutoff extremes so that nothing is selected, in both selections
  task automatic test_none_selected();
    set_all(41, QMIN, 1'b0, 1'b1);
    for (int i = 0; i < 3; i++) send_body(rand_body(1'b1, i == 2));
    wait_idle();
    set_all(41, QMAX, 1'b0, 1'b0);
    for (int i = 0; i < 3; i++) send_body(fill_body(32'h0, i == 2));
    wait_idle();
  endtask

  // direct summation: zero softening with coincident bodies, lone body, max softening
  task automatic test_direct_sum();
    body_in_t b;
    set_all(0, 0, 1'b1, 1'b1);
    for (int i = 0; i < 3; i++) begin
      b = rand_body(1'b0, i == 2);
      for (int k = 0; k < 3; k++) b.pos[k] = 32'h0003_0000;
      b.vel[0] = 32'h0;
      b.vel[1] = 32'h0;
      send_body(b);
    end
    send_body(rand_body(1'b1, 1'b1));
    wait_idle();
    set_all(32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) send_body(rand_body(i[0], i == 3));
    wait_idle();
  endtask

  // random snapshots under random settings
  task automatic test_random();
    int n, r;
    bit wide;
    longint soft_val, cut;
    while (bodies_sent < 350) begin
      r = $urandom_range(0, 9);
      soft_val = (r == 0) ? 0 : (r == 1) ? QMAX : $urandom_range(0, 32'h0004_0000);
      r = $urandom_range(0, 9);
      cut = (r == 0) ? QMIN : (r == 1) ? QMAX :
            longint'(signed'(rand_q(r == 2)));
      set_all(soft_val, cut, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 19);
      n = (r < 14) ? $urandom_range(1, 6) : (r < 19) ? $urandom_range(7, 12) :
          $urandom_range(13, 16);
      if (!exact && $urandom_range(0, 29) == 0) n = $urandom_range(40, MAX_BODIES);
      wide = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) send_body(rand_body(wide, i == n - 1));
      wait_idle();
    end
    quiet = 1'b0;
  endtask

  // result side: random stalls with quiet stretches
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left  <= pick_gap();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    selected_body_t x;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result, index %0d", body_index_o));
      end else begin
        x = pending_q.pop_front();
        if (body_index_o !== x.idx)
          report($sformatf("body_index %0d, want %0d", body_index_o, x.idx));
        if ({out_pos_x_o, out_pos_y_o, out_pos_z_o} !== {x.pos[0], x.pos[1], x.pos[2]})
          report($sformatf("position of body %0d differs", x.idx));
        if ({out_vel_x_o, out_vel_y_o, out_vel_z_o} !== {x.vel[0], x.vel[1], x.vel[2]})
          report($sformatf("velocity of body %0d differs", x.idx));
        if (out_mass_o !== x.mass)
          report($sformatf("out_mass %h, want %h", out_mass_o, x.mass));
        if (total_energy_o !== x.energy)
          report($sformatf("energy of body %0d: %h, want %h", x.idx, total_energy_o, x.energy));
        if (none_selected_o !== x.none)
          report($sformatf("none_selected %b, want %b", none_selected_o, x.none));
        if (last_result_o !== x.last)
          report($sformatf("last_result %b, want %b", last_result_o, x.last));
      end
    end
  end

  // watchdog: too long without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[nbody_unbound_star_filter_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_store_full();
    test_none_selected();
    test_direct_sum();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("[nbody_unbound_star_filter_top] OK");
    end else begin
      $display("[nbody_unbound_star_filter_top] ERROR");
    end
    $finish;
  end

endmodule
